// ----- sv/ajd_pkg.sv -----
package ajd_pkg;

  localparam int CFG_W = 16;
  localparam int TH_W  = 7;
  localparam int PCT_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Calibration margins are pushed this far past the middle when they sit
  // on the wrong side, and middles are raised to at least this value.
  localparam int CAL_DISTANCE = 100;
  localparam logic [TH_W-1:0] PCT_FULL = 7'd100;

  localparam logic [CFG_W-1:0] X_MIDDLE_RST = 16'd32768;
  localparam logic [CFG_W-1:0] X_LEFT_RST   = 16'd0;
  localparam logic [CFG_W-1:0] X_RIGHT_RST  = 16'd65535;
  localparam logic [CFG_W-1:0] Y_MIDDLE_RST = 16'd32768;
  localparam logic [CFG_W-1:0] Y_UPPER_RST  = 16'd0;
  localparam logic [CFG_W-1:0] Y_LOWER_RST  = 16'd65535;
  localparam logic [TH_W-1:0]  THRESH_RST   = 7'd25;

  localparam logic [2:0] REG_X_MIDDLE = 3'd0;
  localparam logic [2:0] REG_X_LEFT   = 3'd1;
  localparam logic [2:0] REG_X_RIGHT  = 3'd2;
  localparam logic [2:0] REG_Y_MIDDLE = 3'd3;
  localparam logic [2:0] REG_Y_UPPER  = 3'd4;
  localparam logic [2:0] REG_Y_LOWER  = 3'd5;
  localparam logic [2:0] REG_THRESH   = 3'd6;
  localparam logic [2:0] REG_ENABLE   = 3'd7;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PRESSED  = 2'd1;
  localparam logic [1:0] EV_HELD     = 2'd2;
  localparam logic [1:0] EV_RELEASED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIXM,
    ST_FIXR,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } ajd_state_t;

endpackage

// ----- sv/analog_joystick_digitizer.sv -----
// An input beat passes the middle fix, margin fix, lane load and compare states; the done
// state loads its result once the output register is free; no new beat is taken meanwhile.
// The bit-serial multiply-compare walks distance and range of all four lanes one bit a cycle.
// One waiting result does not block the next input beat; the output register holds it.
// Reset (synchronous, active high) loads the calibration defaults and clears the
// fault flag, the last button state and all handshake state.
module analog_joystick_digitizer #(
  parameter int AXIS_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [AXIS_BITS-1:0]      x_position,
  input  logic [AXIS_BITS-1:0]      y_position,
  input  logic                      button_one,
  input  logic                      button_two,
  input  logic                      read_ok,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      dir_left,
  output logic                      dir_right,
  output logic                      dir_up,
  output logic                      dir_down,
  output logic                      fire_one,
  output logic                      fire_two,
  output logic [1:0]                button_event,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ajd_pkg::ADDR_W-1:0] paddr,
  input  logic [ajd_pkg::DATA_W-1:0] pwdata,
  output logic [ajd_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);
  import ajd_pkg::*;

  localparam int ACC_W = AXIS_BITS + 9;
  localparam int CNT_W = (AXIS_BITS > 1) ? $clog2(AXIS_BITS) : 1;
  localparam logic [AXIS_BITS-1:0] CAL_A = AXIS_BITS'(CAL_DISTANCE);

  // Configuration registers.
  logic [CFG_W-1:0] x_middle, x_left, x_right, y_middle, y_upper, y_lower;
  logic [TH_W-1:0]  threshold_percent;
  logic             enable;
  logic [2:0]       reg_index;
  logic             reg_write;

  // Control state.
  ajd_state_t state, state_next;
  logic       device_failed;
  logic       last_button;
  logic [CNT_W-1:0] cnt;

  // Item payload.
  logic [AXIS_BITS-1:0] xp, yp;
  logic                 active;
  logic                 f1_pend, f2_pend;
  logic [1:0]           ev_pend;

  // Sanitized calibration.
  logic [AXIS_BITS-1:0] xm, ym, xl, xr, yu, yd;

  // Lanes: 0 left, 1 right, 2 up, 3 down.
  logic [AXIS_BITS-1:0]    dist_sh [4];
  logic [AXIS_BITS-1:0]    rng_sh  [4];
  logic signed [ACC_W-1:0] acc     [4];
  logic signed [ACC_W-1:0] acc_next [4];
  logic [3:0] lane_ok, lane_deg, lane_dnz, lane_hit;
  logic [AXIS_BITS-1:0] ld_dist [4];
  logic [AXIS_BITS-1:0] ld_rng  [4];
  logic [3:0] ld_ok;
  logic [AXIS_BITS-1:0] l_mid [4];
  logic [AXIS_BITS-1:0] l_mar [4];
  logic [AXIS_BITS-1:0] l_pos [4];

  logic in_take, out_load;
  logic act_now, f1_now, f2_now, btn_now;
  logic [PCT_W-1:0] th1;
  logic [AXIS_BITS:0] xr_sum, yd_sum;
  logic [AXIS_BITS-1:0] x_mid_a, y_mid_a, x_left_a, x_right_a, y_upper_a, y_lower_a;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_middle          <= X_MIDDLE_RST;
      x_left            <= X_LEFT_RST;
      x_right           <= X_RIGHT_RST;
      y_middle          <= Y_MIDDLE_RST;
      y_upper           <= Y_UPPER_RST;
      y_lower           <= Y_LOWER_RST;
      threshold_percent <= THRESH_RST;
      enable            <= 1'b0;
    end else if (reg_write) begin
      case (reg_index)
        REG_X_MIDDLE: x_middle          <= pwdata[CFG_W-1:0];
        REG_X_LEFT:   x_left            <= pwdata[CFG_W-1:0];
        REG_X_RIGHT:  x_right           <= pwdata[CFG_W-1:0];
        REG_Y_MIDDLE: y_middle          <= pwdata[CFG_W-1:0];
        REG_Y_UPPER:  y_upper           <= pwdata[CFG_W-1:0];
        REG_Y_LOWER:  y_lower           <= pwdata[CFG_W-1:0];
        REG_THRESH:   threshold_percent <= pwdata[TH_W-1:0];
        REG_ENABLE:   enable            <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_X_MIDDLE: prdata = DATA_W'(x_middle);
      REG_X_LEFT:   prdata = DATA_W'(x_left);
      REG_X_RIGHT:  prdata = DATA_W'(x_right);
      REG_Y_MIDDLE: prdata = DATA_W'(y_middle);
      REG_Y_UPPER:  prdata = DATA_W'(y_upper);
      REG_Y_LOWER:  prdata = DATA_W'(y_lower);
      REG_THRESH:   prdata = DATA_W'(threshold_percent);
      REG_ENABLE:   prdata = DATA_W'(enable);
      default:      prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_FIXM;
      ST_FIXM: state_next = ST_FIXR;
      ST_FIXR: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_RUN;
      ST_RUN:  if (cnt == '0) state_next = ST_DONE;
      ST_DONE: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    out_load = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  assign in_take = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // ---------------- accept: fault, buttons, event ----------------
  // A failed read while enabled sets a sticky fault and the beat counts as idle.
  assign act_now = enable & ~device_failed & read_ok;
  assign f1_now  = act_now & button_one;
  assign f2_now  = act_now & button_two;
  assign btn_now = f1_now | f2_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_failed <= 1'b0;
      last_button   <= 1'b0;
    end else if (in_take) begin
      if (enable && !device_failed && !read_ok) device_failed <= 1'b1;
      last_button <= btn_now;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      xp      <= x_position;
      yp      <= y_position;
      active  <= act_now;
      f1_pend <= f1_now;
      f2_pend <= f2_now;
      if (btn_now) ev_pend <= last_button ? EV_HELD : EV_PRESSED;
      else         ev_pend <= last_button ? EV_RELEASED : EV_NONE;
    end
  end

  // ---------------- calibration cleanup ----------------
  assign x_mid_a   = AXIS_BITS'(x_middle);
  assign y_mid_a   = AXIS_BITS'(y_middle);
  assign x_left_a  = AXIS_BITS'(x_left);
  assign x_right_a = AXIS_BITS'(x_right);
  assign y_upper_a = AXIS_BITS'(y_upper);
  assign y_lower_a = AXIS_BITS'(y_lower);
  assign xr_sum    = {1'b0, xm} + {1'b0, CAL_A};
  assign yd_sum    = {1'b0, ym} + {1'b0, CAL_A};

  always_ff @(posedge clk) begin
    if (state == ST_FIXM) begin
      xm <= (x_mid_a <= CAL_A) ? CAL_A : x_mid_a;
      ym <= (y_mid_a <= CAL_A) ? CAL_A : y_mid_a;
    end
    if (state == ST_FIXR) begin
      xl <= (x_left_a >= xm) ? xm - CAL_A : x_left_a;
      yu <= (y_upper_a >= ym) ? ym - CAL_A : y_upper_a;
      if (x_right_a <= xm) xr <= xr_sum[AXIS_BITS] ? '1 : xr_sum[AXIS_BITS-1:0];
      else                 xr <= x_right_a;
      if (y_lower_a <= ym) yd <= yd_sum[AXIS_BITS] ? '1 : yd_sum[AXIS_BITS-1:0];
      else                 yd <= y_lower_a;
    end
  end

  // ---------------- lane setup ----------------
  // Even lanes have their margin below the middle, odd lanes above it.
  // An upper margin can only equal its middle when saturated at the axis
  // maximum; then any sample away from the middle counts as full deflection.
  always_comb begin
    l_mid[0] = xm; l_mid[1] = xm; l_mid[2] = ym; l_mid[3] = ym;
    l_mar[0] = xl; l_mar[1] = xr; l_mar[2] = yu; l_mar[3] = yd;
    l_pos[0] = xp; l_pos[1] = xp; l_pos[2] = yp; l_pos[3] = yp;
    for (int i = 0; i < 4; i++) begin
      if (i % 2 == 0) begin
        ld_ok[i]   = (l_pos[i] <= l_mid[i]);
        ld_dist[i] = l_mid[i] - l_pos[i];
        ld_rng[i]  = l_mid[i] - l_mar[i];
      end else begin
        ld_rng[i] = l_mar[i] - l_mid[i];
        if (l_mar[i] == l_mid[i]) begin
          ld_ok[i]   = 1'b1;
          ld_dist[i] = l_mid[i] - l_pos[i];
        end else begin
          ld_ok[i]   = (l_pos[i] >= l_mid[i]);
          ld_dist[i] = l_pos[i] - l_mid[i];
        end
      end
    end
  end

  // ---------------- bit-serial compare ----------------
  // pct > th is the same as dist*100 >= (th+1)*range. Both products are
  // formed MSB first, one bit of dist and range per cycle, into one signed
  // accumulator per lane.
  assign th1 = {1'b0, threshold_percent} + PCT_W'(1);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc_next[i] = (acc[i] <<< 1)
                  + (dist_sh[i][AXIS_BITS-1] ? ACC_W'(CAL_DISTANCE) : ACC_W'(0))
                  - (rng_sh[i][AXIS_BITS-1] ? ACC_W'(th1) : ACC_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      cnt <= CNT_W'(AXIS_BITS - 1);
      for (int i = 0; i < 4; i++) begin
        dist_sh[i]  <= ld_dist[i];
        rng_sh[i]   <= ld_rng[i];
        acc[i]      <= '0;
        lane_ok[i]  <= ld_ok[i];
        lane_deg[i] <= (ld_rng[i] == '0);
        lane_dnz[i] <= (ld_dist[i] != '0);
      end
    end else if (state == ST_RUN) begin
      cnt <= cnt - CNT_W'(1);
      for (int i = 0; i < 4; i++) begin
        dist_sh[i] <= dist_sh[i] << 1;
        rng_sh[i]  <= rng_sh[i] << 1;
        acc[i]     <= acc_next[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_hit[i] = active && lane_ok[i] && (threshold_percent < PCT_FULL) &&
                    (lane_deg[i] ? lane_dnz[i] : !acc[i][ACC_W-1]);
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dir_left     <= lane_hit[0];
      dir_right    <= lane_hit[1] & ~lane_hit[0];
      dir_up       <= lane_hit[2];
      dir_down     <= lane_hit[3] & ~lane_hit[2];
      fire_one     <= f1_pend;
      fire_two     <= f2_pend;
      button_event <= ev_pend;
    end
  end

endmodule

// ----- tb/joystick_result_checker.sv -----
`timescale 1ns / 1ps
module joystick_result_checker #(
  parameter int AXIS_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [AXIS_BITS-1:0]       x_position,
  input  logic [AXIS_BITS-1:0]       y_position,
  input  logic                       button_one,
  input  logic                       button_two,
  input  logic                       read_ok,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       dir_left,
  input  logic                       dir_right,
  input  logic                       dir_up,
  input  logic                       dir_down,
  input  logic                       fire_one,
  input  logic                       fire_two,
  input  logic [1:0]                 button_event,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ajd_pkg::ADDR_W-1:0] paddr,
  input  logic [ajd_pkg::DATA_W-1:0] pwdata,
  output int unsigned                pending_reports,
  output int unsigned                mismatches
);
  import ajd_pkg::*;

  localparam longint unsigned AXIS_MAX = (64'd1 << AXIS_BITS) - 64'd1;
  localparam longint unsigned NUDGE    = CAL_DISTANCE;

  typedef struct packed {
    logic       left;
    logic       right;
    logic       up;
    logic       down;
    logic       fire1;
    logic       fire2;
    logic [1:0] event_code;
  } joy_report_t;

  // Shadow copy of the calibration registers, tracked from the write bus.
  logic [CFG_W-1:0] cfg_x_middle, cfg_x_left, cfg_x_right;
  logic [CFG_W-1:0] cfg_y_middle, cfg_y_upper, cfg_y_lower;
  logic [TH_W-1:0]  cfg_threshold;
  logic             cfg_enable;
  logic             device_failed;
  logic             last_pressed;

  joy_report_t report_q[$];

  function automatic longint unsigned raise_middle(input longint unsigned m);
    m &= AXIS_MAX;
    return (m <= NUDGE) ? NUDGE : m;
  endfunction

  function automatic longint unsigned margin_below(input longint unsigned margin,
                                                   input longint unsigned mid);
    margin &= AXIS_MAX;
    if (margin >= mid) begin
      margin = (mid >= NUDGE) ? mid - NUDGE : 64'd0;
    end
    return margin;
  endfunction

  function automatic longint unsigned margin_above(input longint unsigned margin,
                                                   input longint unsigned mid);
    margin &= AXIS_MAX;
    if (margin <= mid) begin
      margin = mid + NUDGE;
      if (margin > AXIS_MAX) begin
        margin = AXIS_MAX;
      end
    end
    return margin;
  endfunction

  function automatic longint unsigned deflection_pct(input longint unsigned mid,
                                                     input longint unsigned margin,
                                                     input longint unsigned pos);
    longint unsigned span, travel, pct;
    if (margin < mid && pos > mid) return 64'd0;
    if (margin > mid && pos < mid) return 64'd0;
    span = (margin > mid) ? margin - mid : mid - margin;
    travel = (pos > mid) ? pos - mid : mid - pos;
    // A margin pinned onto its middle by saturation reports full travel.
    if (span == 0) return (travel != 0) ? 64'd100 : 64'd0;
    pct = travel * 64'd100 / span;
    return (pct > 64'd100) ? 64'd100 : pct;
  endfunction

  function automatic joy_report_t predict_report(input logic [AXIS_BITS-1:0] xp,
                                                 input logic [AXIS_BITS-1:0] yp,
                                                 input logic b1, input logic b2,
                                                 input logic ok);
    joy_report_t r;
    logic live;
    longint unsigned xm, ym, xl, xr, yu, yd, th;
    r = '0;
    live = cfg_enable && !device_failed;
    if (live && !ok) begin
      device_failed = 1'b1;
      live = 1'b0;
    end
    if (live) begin
      xm = raise_middle(64'(cfg_x_middle));
      ym = raise_middle(64'(cfg_y_middle));
      xl = margin_below(64'(cfg_x_left), xm);
      xr = margin_above(64'(cfg_x_right), xm);
      yu = margin_below(64'(cfg_y_upper), ym);
      yd = margin_above(64'(cfg_y_lower), ym);
      th = 64'(cfg_threshold);
      if (deflection_pct(xm, xl, 64'(xp)) > th) begin
        r.left = 1'b1;
      end else if (deflection_pct(xm, xr, 64'(xp)) > th) begin
        r.right = 1'b1;
      end
      if (deflection_pct(ym, yu, 64'(yp)) > th) begin
        r.up = 1'b1;
      end else if (deflection_pct(ym, yd, 64'(yp)) > th) begin
        r.down = 1'b1;
      end
      r.fire1 = b1;
      r.fire2 = b2;
    end
    if (r.fire1 || r.fire2) begin
      r.event_code = last_pressed ? EV_HELD : EV_PRESSED;
    end else begin
      r.event_code = last_pressed ? EV_RELEASED : EV_NONE;
    end
    last_pressed = r.fire1 || r.fire2;
    return r;
  endfunction

  task automatic flag_report(input string what, input joy_report_t want,
                             input joy_report_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected L%b R%b U%b D%b F1=%b F2=%b ev=%0d,",
               $realtime, what, want.left, want.right, want.up, want.down, want.fire1,
               want.fire2, want.event_code,
               " got L%b R%b U%b D%b F1=%b F2=%b ev=%0d",
               got.left, got.right, got.up, got.down,
               got.fire1, got.fire2, got.event_code);
    end
  endtask

  always @(posedge clk) begin : watch_channels
    joy_report_t got, want;
    if (rst) begin
      cfg_x_middle  = X_MIDDLE_RST;
      cfg_x_left    = X_LEFT_RST;
      cfg_x_right   = X_RIGHT_RST;
      cfg_y_middle  = Y_MIDDLE_RST;
      cfg_y_upper   = Y_UPPER_RST;
      cfg_y_lower   = Y_LOWER_RST;
      cfg_threshold = THRESH_RST;
      cfg_enable    = 1'b0;
      device_failed = 1'b0;
      last_pressed  = 1'b0;
      report_q.delete();
      mismatches    = 0;
      pending_reports <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_X_MIDDLE: cfg_x_middle  = pwdata[CFG_W-1:0];
          REG_X_LEFT:   cfg_x_left    = pwdata[CFG_W-1:0];
          REG_X_RIGHT:  cfg_x_right   = pwdata[CFG_W-1:0];
          REG_Y_MIDDLE: cfg_y_middle  = pwdata[CFG_W-1:0];
          REG_Y_UPPER:  cfg_y_upper   = pwdata[CFG_W-1:0];
          REG_Y_LOWER:  cfg_y_lower   = pwdata[CFG_W-1:0];
          REG_THRESH:   cfg_threshold = pwdata[TH_W-1:0];
          REG_ENABLE:   cfg_enable    = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{dir_left, dir_right, dir_up, dir_down, fire_one, fire_two, button_event};
        if (report_q.size() == 0) begin
          flag_report("result beat with nothing expected", '0, got);
        end else begin
          want = report_q.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.up !== want.up || got.down !== want.down ||
              got.fire1 !== want.fire1 || got.fire2 !== want.fire2 ||
              got.event_code !== want.event_code) begin
            flag_report("result mismatch", want, got);
          end
        end
      end
      if (in_valid && !in_stall) begin
        report_q.push_back(predict_report(x_position, y_position, button_one, button_two,
                                          read_ok));
      end
      pending_reports <= report_q.size();
    end
  end

endmodule

// ----- tb/analog_joystick_digitizer_tb.sv -----
`timescale 1ns / 1ps
module analog_joystick_digitizer_tb;
  import ajd_pkg::*;

  localparam int AXIS_BITS      = 16;
  localparam int LATENCY        = AXIS_BITS + 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 180;
  localparam int RANDOM_PHASES  = 10;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [AXIS_BITS-1:0] x_position;
  logic [AXIS_BITS-1:0] y_position;
  logic                 button_one;
  logic                 button_two;
  logic                 read_ok;
  logic                 out_valid;
  logic                 out_stall;
  logic                 dir_left, dir_right, dir_up, dir_down;
  logic                 fire_one, fire_two;
  logic [1:0]           button_event;
  logic                 psel, penable, pwrite, pready;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;

  int unsigned pending_reports;
  int unsigned mismatches;
  int unsigned quiet_cycles = 0;
  int unsigned hold_requests = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  // Calibration that the stimulus last loaded; positions are aimed around it.
  logic [CFG_W-1:0] cal_xm, cal_xl, cal_xr, cal_ym, cal_yu, cal_yd;
  logic [TH_W-1:0]  cal_th;
  logic             cal_en;
  logic [1:0]       held_buttons = 2'b00;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  analog_joystick_digitizer #(
    .AXIS_BITS(AXIS_BITS)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_position(x_position), .y_position(y_position),
    .button_one(button_one), .button_two(button_two), .read_ok(read_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .dir_left(dir_left), .dir_right(dir_right), .dir_up(dir_up), .dir_down(dir_down),
    .fire_one(fire_one), .fire_two(fire_two), .button_event(button_event),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  joystick_result_checker #(
    .AXIS_BITS(AXIS_BITS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_position(x_position), .y_position(y_position),
    .button_one(button_one), .button_two(button_two), .read_ok(read_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .dir_left(dir_left), .dir_right(dir_right), .dir_up(dir_up), .dir_down(dir_down),
    .fire_one(fire_one), .fire_two(fire_two), .button_event(button_event),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pending_reports(pending_reports), .mismatches(mismatches)
  );

  // The run ends if neither channel nor the register port moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : result_side
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (rx_idle_en) begin
        out_stall <= ($urandom_range(99) < 30);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_calibration();
    write_reg(REG_X_MIDDLE, DATA_W'(cal_xm));
    write_reg(REG_X_LEFT, DATA_W'(cal_xl));
    write_reg(REG_X_RIGHT, DATA_W'(cal_xr));
    write_reg(REG_Y_MIDDLE, DATA_W'(cal_ym));
    write_reg(REG_Y_UPPER, DATA_W'(cal_yu));
    write_reg(REG_Y_LOWER, DATA_W'(cal_yd));
    write_reg(REG_THRESH, DATA_W'(cal_th));
    write_reg(REG_ENABLE, DATA_W'(cal_en));
  endtask

  task automatic offer(input logic [AXIS_BITS-1:0] x, input logic [AXIS_BITS-1:0] y,
                       input logic b1, input logic b2, input logic ok);
    while (tx_idle_en && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    x_position <= x;
    y_position <= y;
    button_one <= b1;
    button_two <= b2;
    read_ok    <= ok;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every predicted sample report has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_raw();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return CFG_W'(100 + $urandom_range(1, 0));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [AXIS_BITS-1:0] pick_position(input logic [CFG_W-1:0] mid);
    int p;
    case ($urandom_range(9))
      0, 1: p = int'($urandom_range(65535, 0));
      2: p = 0;
      3: p = 65535;
      4: p = int'(mid);
      default: p = int'(mid) + int'($urandom_range(48000, 0)) - 24000;
    endcase
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return AXIS_BITS'(p);
  endfunction

  task automatic random_phase(input int phase);
    wait_drained();
    if ($urandom_range(9) < 6) begin
      cal_xm = CFG_W'($urandom_range(45000, 20000));
      cal_xl = CFG_W'($urandom_range(cal_xm - 1000, 0));
      cal_xr = CFG_W'($urandom_range(65535, cal_xm + 1000));
      cal_ym = CFG_W'($urandom_range(45000, 20000));
      cal_yu = CFG_W'($urandom_range(cal_ym - 1000, 0));
      cal_yd = CFG_W'($urandom_range(65535, cal_ym + 1000));
    end else begin
      cal_xm = pick_raw();
      cal_xl = pick_raw();
      cal_xr = pick_raw();
      cal_ym = pick_raw();
      cal_yu = pick_raw();
      cal_yd = pick_raw();
    end
    case (phase)
      0: cal_th = 7'd0;
      1: cal_th = 7'd100;
      5: cal_th = 7'd127;
      default: begin
        cal_th = ($urandom_range(9) == 0) ? TH_W'($urandom_range(127, 101))
                                          : TH_W'($urandom_range(100, 0));
      end
    endcase
    cal_en = (phase % 4 != 3);
    tx_idle_en = (phase != 2);
    rx_idle_en = (phase != 2);
    load_calibration();
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (phase == 4 && n == 40) hold_requests++;
      if (phase == 6 && n == 90) wait_drained();
      if ($urandom_range(9) < 3) held_buttons = 2'($urandom_range(3, 0));
      // A failed read latches for good, so enabled phases only send good reads.
      offer(pick_position(cal_xm), pick_position(cal_ym), held_buttons[0], held_buttons[1],
            cal_en ? 1'b1 : 1'($urandom_range(1, 0)));
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    x_position = '0;
    y_position = '0;
    button_one = 1'b0;
    button_two = 1'b0;
    read_ok    = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration, still disabled: bad reads and buttons are ignored.
    offer(16'h0000, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    offer(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b1);
    wait_drained();
    write_reg(REG_ENABLE, DATA_W'(1));
    offer(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
    offer(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    offer(16'd32768, 16'd32768, 1'b0, 1'b1, 1'b1);
    // Exactly on and just past the default threshold.
    offer(16'd24576, 16'd40960, 1'b0, 1'b0, 1'b1);
    offer(16'd24248, 16'd41288, 1'b1, 1'b1, 1'b1);
    offer(16'hAAAA, 16'h5555, 1'b1, 1'b1, 1'b1);
    offer(16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b1);
    wait_drained();
    write_reg(REG_THRESH, DATA_W'(0));
    offer(16'd32767, 16'd32769, 1'b0, 1'b0, 1'b1);
    offer(16'd32000, 16'd33600, 1'b0, 1'b0, 1'b1);
    wait_drained();
    write_reg(REG_THRESH, DATA_W'(100));
    offer(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    wait_drained();
    write_reg(REG_THRESH, DATA_W'(127));
    offer(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
    wait_drained();
    // Low middles get raised, wrong-side margins get moved, and the lower
    // Y margin saturates onto its middle.
    cal_xm = 16'd0;
    cal_xl = 16'hFFFF;
    cal_xr = 16'd0;
    cal_ym = 16'hFFFF;
    cal_yu = 16'd0;
    cal_yd = 16'd100;
    cal_th = 7'd50;
    cal_en = 1'b1;
    load_calibration();
    offer(16'd150, 16'd65534, 1'b0, 1'b0, 1'b1);
    offer(16'd300, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    offer(16'd0, 16'd0, 1'b0, 1'b0, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_phase(p);
    end

    // Last of all, a failed read with a button held: one release event, then
    // the fault keeps every report at zero.
    wait_drained();
    cal_xm = 16'd32768;
    cal_xl = 16'd1000;
    cal_xr = 16'd64000;
    cal_ym = 16'd30000;
    cal_yu = 16'd500;
    cal_yd = 16'd65000;
    cal_th = 7'd10;
    cal_en = 1'b1;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    load_calibration();
    for (int n = 0; n < 8; n++) begin
      offer(pick_position(cal_xm), pick_position(cal_ym), 1'b1, n[0], 1'b1);
    end
    offer(16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0);
    for (int n = 0; n < 12; n++) begin
      offer(AXIS_BITS'($urandom), AXIS_BITS'($urandom), 1'($urandom_range(1, 0)),
            1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- analog_joystick_digitizer.f -----
sv/ajd_pkg.sv
sv/analog_joystick_digitizer.sv
tb/joystick_result_checker.sv
tb/analog_joystick_digitizer_tb.sv
